@@ rtl/crp_pkg.sv @@
// Clock replacer package: command and state codes, frame entry layout, field widths.
// Self-contained; imported by clock_page_replacer_top.
package crp_pkg;

  localparam int NUM_FRAMES_DEF = 64;

  localparam int CMD_W   = 2;
  localparam int IDX_W   = 6;
  localparam int COUNT_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_VICTIM = 2'd0,
    CMD_PIN    = 2'd1,
    CMD_UNPIN  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_SWEEP
  } state_t;

  typedef struct packed {
    logic pinned;
    logic referenced;
  } entry_t;

endpackage

@@ rtl/clock_page_replacer_top.sv @@
// Clock (second-chance) page replacer: pin, unpin and victim sweep over frame memory.
// Pin, unpin, unknown command or victim with no evictable frame: a read-modify-write state
// with busy high, then the result is registered onto done as busy falls.
// Victim sweep: one frame visited per cycle (up to 2*NUM_FRAMES frames), set by the single memory
// read port; the chosen frame is registered onto done, with busy already low.
// Reset: a clearing pass writes every frame pinned, busy held high.
// Results cannot be stalled by the receiver; done marks a single-cycle result.
// Depends on crp_pkg and crp_ram.
module clock_page_replacer_top
  import crp_pkg::*;
#(
  parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [CMD_W-1:0]   command,
  input  logic [IDX_W-1:0]   frame_index,
  output logic               done,
  output logic               found,
  output logic [IDX_W-1:0]   victim_frame,
  output logic [COUNT_W-1:0] evictable_count
);

  localparam int AW = $clog2(NUM_FRAMES);
  localparam int CW = $clog2(NUM_FRAMES + 1);
  // Wide enough to compare the frame index port against NUM_FRAMES.
  localparam int IW = ((AW > IDX_W) ? AW : IDX_W) + 1;
  localparam logic [AW-1:0] LAST = AW'(NUM_FRAMES - 1);

  // Control and state registers
  state_t        state, state_next;
  logic [AW-1:0] hand, hand_next;
  logic [CW-1:0] count, count_next;
  // Address under examination; doubles as the clearing counter after reset.
  logic [AW-1:0] cur, cur_next;
  cmd_t          cmd_q;
  logic          in_range_q;

  // Result registers
  logic               done_next;
  logic               found_next;
  logic [IDX_W-1:0]   victim_frame_next;
  logic [COUNT_W-1:0] evictable_count_next;

  // Frame memory ports
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  entry_t        wr_data, rd_data;

  logic [IW-1:0] idx_wide;
  logic          idx_in_range;
  logic          accept;
  logic [AW-1:0] cur_inc;

  assign idx_wide     = IW'(frame_index);
  assign idx_in_range = idx_wide < IW'(NUM_FRAMES);
  assign busy         = (state != ST_IDLE);
  assign accept       = start && !busy;
  assign cur_inc      = (cur == LAST) ? '0 : cur + AW'(1);

  crp_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_FRAMES)
  ) u_frames (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      hand  <= '0;
      count <= '0;
      cur   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      hand  <= hand_next;
      count <= count_next;
      cur   <= cur_next;
      done  <= done_next;
    end
  end

  // Payload: captured command and result fields need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q      <= cmd_t'(command);
      in_range_q <= idx_in_range;
    end
    if (done_next) begin
      found           <= found_next;
      victim_frame    <= victim_frame_next;
      evictable_count <= evictable_count_next;
    end
  end

  always_comb begin
    state_next           = state;
    hand_next            = hand;
    count_next           = count;
    cur_next             = cur;
    done_next            = 1'b0;
    found_next           = 1'b0;
    victim_frame_next    = '0;
    evictable_count_next = COUNT_W'(count);
    wr_en                = 1'b0;
    wr_addr              = cur;
    wr_data              = '{pinned: 1'b1, referenced: 1'b0};
    rd_en                = 1'b0;
    rd_addr              = cur;

    unique case (state)
      ST_CLEAR: begin
        // Sweep every frame to pinned, unreferenced.
        wr_en    = 1'b1;
        cur_next = cur_inc;
        if (cur == LAST) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          rd_en = 1'b1;
          if (cmd_t'(command) == CMD_VICTIM && count != '0) begin
            // Start the sweep at the hand.
            rd_addr    = hand;
            cur_next   = hand;
            state_next = ST_SWEEP;
          end else begin
            rd_addr    = idx_wide[AW-1:0];
            cur_next   = idx_wide[AW-1:0];
            state_next = ST_MOD;
          end
        end
      end

      ST_MOD: begin
        // Read-modify-write of the addressed frame, then report.
        priority case (1'b1)
          (cmd_q == CMD_PIN) && in_range_q && !rd_data.pinned: begin
            wr_en   = 1'b1;
            wr_data = '{pinned: 1'b1, referenced: rd_data.referenced};
            if (count != '0) begin
              count_next = count - CW'(1);
            end
          end
          (cmd_q == CMD_UNPIN) && in_range_q && rd_data.pinned: begin
            wr_en      = 1'b1;
            wr_data    = '{pinned: 1'b0, referenced: 1'b1};
            count_next = count + CW'(1);
          end
          default: begin
          end
        endcase
        done_next            = 1'b1;
        evictable_count_next = COUNT_W'(count_next);
        state_next           = ST_IDLE;
      end

      ST_SWEEP: begin
        if (rd_data.pinned) begin
          // Skip; read the next frame.
          rd_en    = 1'b1;
          rd_addr  = cur_inc;
          cur_next = cur_inc;
        end else if (rd_data.referenced) begin
          // Drop the second chance and move on.
          wr_en    = 1'b1;
          wr_data  = '{pinned: 1'b0, referenced: 1'b0};
          rd_en    = 1'b1;
          rd_addr  = cur_inc;
          cur_next = cur_inc;
        end else begin
          // Victim: pin it and park the hand one past it.
          wr_en                = 1'b1;
          wr_data              = '{pinned: 1'b1, referenced: 1'b0};
          count_next           = count - CW'(1);
          hand_next            = cur_inc;
          done_next            = 1'b1;
          found_next           = 1'b1;
          victim_frame_next    = IDX_W'(cur);
          evictable_count_next = COUNT_W'(count_next);
          state_next           = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_CLEAR;
        cur_next   = '0;
      end
    endcase
  end

  // The count never exceeds the number of frames.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(NUM_FRAMES))
    else $error("evictable count above frame total");

  // The hand stays inside the frame range.
  a_hand_bound: assert property (@(posedge clk) disable iff (rst)
    hand <= LAST)
    else $error("clock hand out of range");

  // A write and a read of the same frame never coincide.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("frame memory read and write collide");

  // A found result only comes out of a sweep.
  a_found_from_sweep: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> ($past(state) == ST_SWEEP))
    else $error("found reported outside a sweep");

  // Non-victim transfers report their result without a sweep.
  a_short_latency: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd_t'(command) != CMD_VICTIM) |-> ##2 done)
    else $error("pin or unpin result missing");

endmodule

@@ rtl/crp_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module crp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ tb/tb_clock_page_replacer_top.sv @@
// Testbench for clock_page_replacer_top: directed and random pin, unpin and victim traffic.
// Predicts every result with its own clock-sweep model; depends on crp_pkg and the RTL only.
module tb_clock_page_replacer_top
  import crp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_FRAMES = NUM_FRAMES_DEF;
  // Command code 3 is not defined by the package; the block must treat it as a no-op.
  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
  // Longest victim sweep plus margin, used for the final drain.
  localparam int SWEEP_CYCLES = 2 * NUM_FRAMES + 8;

  typedef struct {
    logic               found;
    logic [IDX_W-1:0]   frame;
    logic [COUNT_W-1:0] count;
  } replacer_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [CMD_W-1:0]   command = '0;
  logic [IDX_W-1:0]   frame_index = '0;
  logic               busy;
  logic               done;
  logic               found;
  logic [IDX_W-1:0]   victim_frame;
  logic [COUNT_W-1:0] evictable_count;

  // Predicted replacer state: one pinned and one reference bit per frame, hand and count.
  logic [NUM_FRAMES-1:0] frame_pinned = '1;
  logic [NUM_FRAMES-1:0] frame_ref = '0;
  int                    hand = 0;
  int                    evict_cnt = 0;

  replacer_result_t outcome_q[$];

  int  err_count = 0;
  int  items_sent = 0;
  int  results_checked = 0;
  int  victims_found = 0;
  int  victims_empty = 0;
  int  peak_count = 0;
  // When set, the sender issues back-to-back transfers with no idle cycles.
  bit  no_idle = 1'b0;

  clock_page_replacer_top #(
    .NUM_FRAMES(NUM_FRAMES)
  ) dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .command         (command),
    .frame_index     (frame_index),
    .done            (done),
    .found           (found),
    .victim_frame    (victim_frame),
    .evictable_count (evictable_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Advance the predicted state by one command and return the result it produces.
  // A victim sweep skips pinned frames, clears set reference bits (second chance) and
  // takes the first unpinned frame with a clear reference bit; the hand ends one past it.
  function automatic replacer_result_t predict_outcome(logic [CMD_W-1:0] cmd,
                                                       logic [IDX_W-1:0] idx);
    replacer_result_t res;
    bit               picked;
    res.found = 1'b0;
    res.frame = '0;
    picked    = 1'b0;
    case (cmd)
      CMD_VICTIM: begin
        if (evict_cnt != 0) begin
          for (int steps = 0; steps < 2 * NUM_FRAMES && !picked; steps++) begin
            if (frame_pinned[hand]) begin
              // pinned: pass over
            end else if (frame_ref[hand]) begin
              frame_ref[hand] = 1'b0;
            end else begin
              frame_pinned[hand] = 1'b1;
              evict_cnt--;
              res.found = 1'b1;
              res.frame = hand[IDX_W-1:0];
              picked    = 1'b1;
            end
            hand = (hand == NUM_FRAMES - 1) ? 0 : hand + 1;
          end
        end
      end
      CMD_PIN: begin
        if (idx < NUM_FRAMES && !frame_pinned[idx]) begin
          frame_pinned[idx] = 1'b1;
          if (evict_cnt != 0) evict_cnt--;
        end
      end
      CMD_UNPIN: begin
        if (idx < NUM_FRAMES && frame_pinned[idx]) begin
          frame_pinned[idx] = 1'b0;
          frame_ref[idx]    = 1'b1;
          evict_cnt++;
        end
      end
      default: begin
        // reserved command: state untouched
      end
    endcase
    res.count = evict_cnt[COUNT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= 30) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Send one command. Wait out a random gap first (unless no_idle is set), then hold
  // start until the transfer edge, where busy is low. The prediction is queued at that edge.
  // start is left high so a following item can reuse it without a low/high pair in one step.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx);
    int               gap;
    replacer_result_t want;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    command     <= cmd;
    frame_index <= idx;
    do @(posedge clk); while (busy);
    want = predict_outcome(cmd, idx);
    outcome_q.push_back(want);
    items_sent++;
    if (evict_cnt > peak_count) peak_count = evict_cnt;
    if (cmd == CMD_VICTIM) begin
      if (want.found) victims_found++;
      else victims_empty++;
    end
  endtask

  // Compare every strobed result against the oldest prediction, field by field.
  always @(posedge clk) begin
    replacer_result_t want;
    if (!rst && done) begin
      if (outcome_q.size() == 0) begin
        report_mismatch($sformatf("result with none pending (found=%0d frame=%0d count=%0d)",
                                  found, victim_frame, evictable_count));
      end else begin
        want = outcome_q.pop_front();
        results_checked++;
        if (found !== want.found)
          report_mismatch($sformatf("found %0d, predicted %0d", found, want.found));
        if (victim_frame !== want.frame)
          report_mismatch($sformatf("victim_frame %0d, predicted %0d",
                                    victim_frame, want.frame));
        if (evictable_count !== want.count)
          report_mismatch($sformatf("evictable_count %0d, predicted %0d",
                                    evictable_count, want.count));
      end
    end
  end

  // Straight out of reset: an empty replacer, a pin of an already pinned frame and the reserved command.
  task automatic test_after_reset();
    send_item(CMD_VICTIM, 6'd0);
    send_item(CMD_PIN, 6'd5);
    send_item(CMD_RESERVED, 6'd63);
    send_item(CMD_RESERVED, 6'd0);
    send_item(CMD_VICTIM, 6'd63);
  endtask

  // Extreme and alternating-bit frame numbers, repeats, and a sweep that must wrap.
  task automatic test_frame_extremes();
    send_item(CMD_UNPIN, 6'd0);
    send_item(CMD_UNPIN, 6'd63);
    send_item(CMD_UNPIN, 6'd63);
    send_item(CMD_UNPIN, 6'd42);
    send_item(CMD_UNPIN, 6'd21);
    send_item(CMD_PIN, 6'd42);
    send_item(CMD_PIN, 6'd42);
    send_item(CMD_RESERVED, 6'd21);
    // Every candidate has its second chance set, so the first sweep clears all of them,
    // wraps past frame 63 and comes back to frame 0.
    send_item(CMD_VICTIM, 6'd0);
    send_item(CMD_VICTIM, 6'd63);
    send_item(CMD_VICTIM, 6'd42);
    send_item(CMD_VICTIM, 6'd0);
    send_item(CMD_VICTIM, 6'd21);
  endtask

  // Unpin every frame in shuffled order (count reaches its maximum), then request NUM_FRAMES + 1
  // victims, which evict every unpinned frame and meet the empty replacer at the end.
  task automatic test_fill_drain(input bit back_to_back);
    int order[NUM_FRAMES];
    int j;
    int tmp;
    no_idle = back_to_back;
    for (int i = 0; i < NUM_FRAMES; i++) order[i] = i;
    for (int i = NUM_FRAMES - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < NUM_FRAMES; i++) send_item(CMD_UNPIN, order[i][IDX_W-1:0]);
    // Re-pin a few so the sweep has pinned frames to pass over.
    for (int i = 0; i < 6; i++) send_item(CMD_PIN, IDX_W'($urandom_range(0, NUM_FRAMES - 1)));
    for (int i = 0; i < NUM_FRAMES + 1; i++) send_item(CMD_VICTIM, IDX_W'($urandom));
    no_idle = 1'b0;
  endtask

  // Mixed traffic in segments. Each segment picks a working set of frames (small sets give
  // many repeated pins and unpins), an idle mode, and a command mix.
  task automatic test_random_mix(input int num_items);
    int sent;
    int span;
    int base;
    int roll;
    int unpin_pct;
    logic [IDX_W-1:0] idx;
    sent = 0;
    while (sent < num_items) begin
      case ($urandom_range(0, 2))
        0: span = 4;
        1: span = 16;
        default: span = NUM_FRAMES;
      endcase
      base      = $urandom_range(0, NUM_FRAMES - 1);
      no_idle   = ($urandom_range(0, 3) == 0);
      unpin_pct = $urandom_range(25, 50);
      for (int k = 0; k < 50 && sent < num_items; k++) begin
        idx  = IDX_W'((base + $urandom_range(0, span - 1)) % NUM_FRAMES);
        roll = $urandom_range(0, 99);
        if (roll < unpin_pct) send_item(CMD_UNPIN, idx);
        else if (roll < unpin_pct + 30) send_item(CMD_VICTIM, IDX_W'($urandom));
        else if (roll < 95) send_item(CMD_PIN, idx);
        else send_item(CMD_RESERVED, IDX_W'($urandom));
        sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_after_reset();
    test_frame_extremes();
    test_fill_drain(1'b0);
    test_random_mix(700);
    test_fill_drain(1'b1);
    test_random_mix(750);

    // Drop start at the last transfer edge, then drain the pending results.
    start <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    // Allow time for any stray extra result to show up.
    repeat (SWEEP_CYCLES) @(posedge clk);

    $display("Sent %0d commands, checked %0d results; %0d victims chosen, %0d empty requests.",
             items_sent, results_checked, victims_found, victims_empty);
    $display("Peak evictable count %0d of %0d frames; %0d mismatches.",
             peak_count, NUM_FRAMES, err_count);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #10ms;
    $display("Timeout: transfers or results stopped arriving.");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
